@@ rtl/cqt_pkg.sv @@
// Shared widths and stage types for the contact quality tracker.
`default_nettype none

package cqt_pkg;

    localparam int CH_W     = 5;
    localparam int SAMPLE_W = 16;
    localparam int PT_W     = 16;
    localparam int Q_W      = 15;

    localparam int S_DATA_W = 24;   // channel + sample, padded to bytes
    localparam int M_DATA_W = 40;   // channel + peak-trough + quality, padded

    // 31*pt +/- sample before the >>5
    localparam int PT_SUM_W = 23;
    // 15*q + pt before the >>4
    localparam int Q_SUM_W  = 21;

    localparam int CMP_W    = 9;    // holds any channel count up to 256

    typedef struct packed {
        logic [CH_W-1:0] channel;
        logic            phase;
        logic            in_range;
    } cqt_stage_t;

endpackage

`default_nettype wire

@@ rtl/contact_quality_tracker_unit.sv @@
// Contact quality tracker: per-channel peak-to-trough and quality averages.
//
// Usage:
//   Input transfers on s_* carry one channel sample each; s_tuser raises to
//   flip the shared square-wave phase before that sample is applied.
//   Every input transfer yields exactly one output transfer on m_*, in order,
//   carrying the channel, the phase used, the new peak-to-trough average
//   and the channel's quality average.
//   Items pass the update stage, then the output register. One transfer per
//   cycle is sustained while m_tready stays high: channel state sits in a
//   registered-read RAM, read on input transfer, written back as the item
//   leaves the update stage and forwarded to a back-to-back same-channel item.
//   Reset clears the phase and marks every channel entry as unwritten, so
//   it reads as zero; no clearing pass is needed and input is taken at once.
//   When the receiver stalls, the result waits in the output register, one
//   more item waits in the update stage, and s_tready then drops.
//   Channels at or beyond CHANNELS leave state untouched and report zeros.
`default_nettype none

module contact_quality_tracker_unit #(
    parameter int CHANNELS = 32
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    input  wire  [cqt_pkg::S_DATA_W-1:0]    s_tdata,   // channel[4:0], sample[20:5]
    input  wire                             s_tuser,   // toggle_phase
    output logic                            m_tvalid,
    input  wire                             m_tready,
    output logic [cqt_pkg::M_DATA_W-1:0]    m_tdata,   // channel_out[4:0],
                                                       // swing_out[20:5],
                                                       // quality_out[35:21]
    output logic                            m_tuser    // phase_out
);

    import cqt_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CMP_W-1:0] CH_LIMIT = CMP_W'(CHANNELS);
    localparam int ENTRY_W = PT_W + Q_W;

    // input side
    logic [CH_W-1:0]     in_channel;
    logic [SAMPLE_W-1:0] in_sample;
    logic                in_accept;
    logic                in_range;
    logic [IDX_W-1:0]    in_idx;

    assign in_channel = s_tdata[CH_W-1:0];
    assign in_sample  = s_tdata[CH_W +: SAMPLE_W];
    assign in_accept  = s_tvalid && s_tready;
    assign in_range   = CMP_W'(in_channel) < CH_LIMIT;
    assign in_idx     = IDX_W'(in_channel);

    logic phase_reg;
    logic phase_next;

    assign phase_next = phase_reg ^ s_tuser;

    // state memory and per-entry written flags
    logic [ENTRY_W-1:0]  entry_mem [CHANNELS];
    logic [CHANNELS-1:0] entry_valid_reg;
    logic [ENTRY_W-1:0]  rdata_reg;
    logic                rvalid_reg;

    // update stage
    cqt_stage_t          s1_reg;
    logic                s1_valid_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic                fwd_hit_reg;
    logic [ENTRY_W-1:0]  fwd_data_reg;

    // output register
    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic                out_phase_reg;

    logic out_free;
    logic s1_adv;

    assign out_free = !out_valid_reg || m_tready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;

    // update arithmetic
    logic signed [PT_W-1:0]     old_pt;
    logic        [Q_W-1:0]      old_q;
    logic        [ENTRY_W-1:0]  old_entry;
    logic signed [PT_SUM_W-1:0] pt_ext;
    logic signed [PT_SUM_W-1:0] pt_x31;
    logic signed [PT_SUM_W-1:0] s_ext;
    logic signed [PT_SUM_W-1:0] pt_sum;
    logic signed [PT_SUM_W-1:0] pt_shr;
    logic signed [PT_W-1:0]     new_pt;
    logic signed [Q_SUM_W-1:0]  q_x15;
    logic signed [Q_SUM_W-1:0]  q_sum;
    logic signed [Q_SUM_W-1:0]  q_shr;
    logic        [Q_W-1:0]      new_q;
    logic        [Q_W-1:0]      res_q;
    logic        [PT_W-1:0]     res_pt;

    always_comb
    begin
        if (fwd_hit_reg)
        begin
            old_entry = fwd_data_reg;
        end
        else if (rvalid_reg)
        begin
            old_entry = rdata_reg;
        end
        else
        begin
            old_entry = '0;
        end
        old_pt = old_entry[PT_W-1:0];
        old_q  = old_entry[PT_W +: Q_W];

        pt_ext = PT_SUM_W'(old_pt);
        pt_x31 = (pt_ext <<< 5) - pt_ext;
        s_ext  = $signed({{(PT_SUM_W-SAMPLE_W){1'b0}}, s1_sample_reg});
        if (s1_reg.phase)
        begin
            pt_sum = pt_x31 - s_ext;
        end
        else
        begin
            pt_sum = pt_x31 + s_ext;
        end
        pt_shr = pt_sum >>> 5;
        new_pt = pt_shr[PT_W-1:0];

        q_x15 = $signed({{(Q_SUM_W-Q_W){1'b0}}, old_q} << 4)
              - $signed({{(Q_SUM_W-Q_W){1'b0}}, old_q});
        q_sum = q_x15 + Q_SUM_W'(new_pt);
        q_shr = q_sum >>> 4;
        if (!s1_reg.phase)
        begin
            new_q = old_q;
        end
        else if (q_shr < 0)
        begin
            new_q = '0;
        end
        else
        begin
            new_q = q_shr[Q_W-1:0];
        end

        if (s1_reg.in_range)
        begin
            res_pt = new_pt;
            res_q  = new_q;
        end
        else
        begin
            res_pt = '0;
            res_q  = '0;
        end
    end

    // memory read and write-back
    always_ff @(posedge clk)
    begin
        if (in_accept && in_range)
        begin
            rdata_reg <= entry_mem[in_idx];
        end
        if (s1_adv && s1_reg.in_range)
        begin
            entry_mem[IDX_W'(s1_reg.channel)] <= {new_q, new_pt};
        end
    end

    // control and pipeline registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= 1'b0;
            entry_valid_reg <= '0;
            rvalid_reg      <= 1'b0;
            s1_valid_reg    <= 1'b0;
            fwd_hit_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (s1_adv && s1_reg.in_range)
            begin
                entry_valid_reg[IDX_W'(s1_reg.channel)] <= 1'b1;
            end
            if (in_accept)
            begin
                phase_reg    <= phase_next;
                rvalid_reg   <= in_range && entry_valid_reg[in_idx];
                fwd_hit_reg  <= s1_adv && s1_reg.in_range && (s1_reg.channel == in_channel);
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_reg.channel  <= in_channel;
            s1_reg.phase    <= phase_next;
            s1_reg.in_range <= in_range;
            s1_sample_reg   <= in_sample;
            fwd_data_reg    <= {new_q, new_pt};
        end
        if (s1_adv)
        begin
            out_data_reg  <= {{(M_DATA_W-CH_W-PT_W-Q_W){1'b0}}, res_q, res_pt, s1_reg.channel};
            out_phase_reg <= s1_reg.phase;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_phase_reg;

`ifndef SYNTHESIS
    a_stage_to_output: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_free |=> m_tvalid)
        else $error("update stage result not loaded into output register");

    a_ready_only_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> s1_valid_reg && m_tvalid && !m_tready)
        else $error("input stalled while pipeline has room");

    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tvalid && s_tready && s_tuser) |=> phase_reg == $past(phase_reg))
        else $error("phase changed without a toggle transfer");

    a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !(CMP_W'(m_tdata[CH_W-1:0]) < CH_LIMIT)
        |-> m_tdata[M_DATA_W-1:CH_W] == '0)
        else $error("out-of-range channel reported nonzero state");
`endif

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the contact quality tracker unit.
`default_nettype none

module tb_top;
    import cqt_pkg::*;

    localparam int NUM_CHANNELS    = 32;
    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 7;
    localparam int DIRECTED_ROWS   = 20;
    localparam int ITEMS_PER_PHASE = 400;
    localparam int RX_HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES    = 8;
    localparam int TIMEOUT_CYCLES  = 200000;

    typedef struct {
        logic [CH_W-1:0]            channel;
        logic                       phase;
        logic signed [PT_W-1:0]     swing;
        logic [Q_W-1:0]             quality;
    } channel_update_t;

    typedef struct {
        logic [CH_W-1:0]     channel;
        logic [SAMPLE_W-1:0] sample;
        logic                toggle;
        bit                  fixed;
        channel_update_t     fixed_update;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata;    // channel, sample
    logic                   s_tuser;    // toggle_phase
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_DATA_W-1:0]    m_tdata;    // channel_out, swing_out, quality_out
    logic                   m_tuser;    // phase_out

    // predictor state
    logic                   drive_phase;
    logic signed [PT_W-1:0] pt_avg [NUM_CHANNELS];
    logic [Q_W-1:0]         q_avg [NUM_CHANNELS];

    channel_update_t        expected_updates [$];
    stim_row_t              directed_rows [DIRECTED_ROWS];
    int                     errors;
    int                     tx_idle_pct;
    int                     rx_idle_pct;
    bit                     rx_hold_req;

    contact_quality_tracker_unit #(
        .CHANNELS (NUM_CHANNELS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #HALF_PERIOD clk = ~clk;

    function automatic channel_update_t track_contact(input logic [CH_W-1:0] ch,
                                                      input logic [SAMPLE_W-1:0] sample,
                                                      input logic toggle);
        channel_update_t upd;
        int              pt_sum;
        int              q_sum;
        logic signed [PT_W-1:0] pt_new;
        if (toggle)
        begin
            drive_phase = ~drive_phase;
        end
        upd.channel     = ch;
        upd.phase       = drive_phase;
        upd.swing       = '0;
        upd.quality     = '0;
        if (int'(ch) < NUM_CHANNELS)
        begin
            if (drive_phase)
            begin
                pt_sum = 31 * int'(pt_avg[ch]) - int'(sample);
            end
            else
            begin
                pt_sum = 31 * int'(pt_avg[ch]) + int'(sample);
            end
            pt_new = PT_W'(pt_sum >>> 5);
            pt_avg[ch] = pt_new;
            if (drive_phase)
            begin
                q_sum = (15 * int'(q_avg[ch]) + int'(pt_new)) >>> 4;
                if (q_sum < 0)
                begin
                    q_sum = 0;
                end
                q_avg[ch] = Q_W'(q_sum);
            end
            upd.swing       = pt_new;
            upd.quality     = q_avg[ch];
        end
        return upd;
    endfunction

    function automatic stim_row_t make_row(input int ch, input int sample, input int toggle,
                                           input bit fixed, input int ph, input int pt,
                                           input int q);
        stim_row_t row;
        row.channel                  = CH_W'(ch);
        row.sample                   = SAMPLE_W'(sample);
        row.toggle                   = toggle[0];
        row.fixed                    = fixed;
        row.fixed_update.channel     = CH_W'(ch);
        row.fixed_update.phase       = ph[0];
        row.fixed_update.swing       = PT_W'(pt);
        row.fixed_update.quality     = Q_W'(q);
        return row;
    endfunction

    // enters and leaves at a falling edge
    task automatic send_sample(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] sample,
                               input logic toggle, input bit fixed,
                               input channel_update_t fixed_update);
        channel_update_t predicted;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'({sample, ch});
        s_tuser  <= toggle;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        predicted = track_contact(ch, sample, toggle);
        expected_updates.push_back(fixed ? fixed_update : predicted);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_updates.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // bursts: square-wave drive on a few hot channels, constant-sample runs, and noise
    task automatic run_random(input int target);
        int                  sent;
        int                  mode;
        int                  len;
        int                  base;
        int                  hot;
        int                  half;
        logic [CH_W-1:0]     ch;
        logic [SAMPLE_W-1:0] smp;
        logic [SAMPLE_W-1:0] sat_sample;
        logic                tg;
        logic                next_phase;
        channel_update_t     unused;
        unused = '{default: '0};
        sent = 0;
        while (sent < target)
        begin
            mode = $urandom_range(0, 9);
            if (mode <= 5)
            begin
                len = $urandom_range(16, 48);
            end
            else if (mode <= 7)
            begin
                len = 40;
            end
            else
            begin
                len = $urandom_range(8, 32);
            end
            base       = $urandom_range(0, NUM_CHANNELS - 1);
            hot        = $urandom_range(1, 4);
            half       = $urandom_range(1, 8);
            sat_sample = $urandom_range(0, 1) ? '1 : SAMPLE_W'($urandom_range(0, 65535));
            for (int i = 0; i < len; i++)
            begin
                if (mode <= 5)
                begin
                    ch         = CH_W'(base + $urandom_range(0, hot - 1));
                    tg         = (i % half) == 0;
                    next_phase = drive_phase ^ tg;
                    if ($urandom_range(0, 7) == 0)
                    begin
                        smp = SAMPLE_W'($urandom_range(0, 65535));
                    end
                    else if (next_phase)
                    begin
                        smp = SAMPLE_W'($urandom_range(0, 16383));
                    end
                    else
                    begin
                        smp = SAMPLE_W'($urandom_range(49152, 65535));
                    end
                end
                else if (mode <= 7)
                begin
                    ch  = CH_W'(base);
                    tg  = $urandom_range(0, 19) == 0;
                    smp = sat_sample;
                end
                else
                begin
                    ch  = CH_W'($urandom_range(0, NUM_CHANNELS - 1));
                    tg  = 1'($urandom_range(0, 1));
                    smp = SAMPLE_W'($urandom_range(0, 65535));
                end
                send_sample(ch, smp, tg, 1'b0, unused);
                sent++;
            end
        end
    endtask

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES - 1)
                begin
                    @(negedge clk);
                    m_tready <= 1'b0;
                end
            end
            else if (!rst_n)
            begin
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= $urandom_range(0, 99) >= rx_idle_pct;
            end
        end
    end

    always @(posedge clk)
    begin : check_updates
        channel_update_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_updates.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected transfer, expected none, actual channel %0d",
                         $time, m_tdata[4:0]);
            end
            else
            begin
                want = expected_updates.pop_front();
                if (m_tdata[4:0] !== want.channel)
                begin
                    errors++;
                    $display("%0t: channel_out expected %0d, actual %0d",
                             $time, want.channel, m_tdata[4:0]);
                end
                if (m_tuser !== want.phase)
                begin
                    errors++;
                    $display("%0t: phase_out expected %0d, actual %0d",
                             $time, want.phase, m_tuser);
                end
                if (m_tdata[20:5] !== want.swing)
                begin
                    errors++;
                    $display("%0t: swing_out expected %0d, actual %0d",
                             $time, want.swing, $signed(m_tdata[20:5]));
                end
                if (m_tdata[35:21] !== want.quality)
                begin
                    errors++;
                    $display("%0t: quality_out expected %0d, actual %0d",
                             $time, want.quality, m_tdata[35:21]);
                end
            end
        end
    end

    initial
    begin
        #(2 * HALF_PERIOD * TIMEOUT_CYCLES);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        errors      = 0;
        rx_hold_req = 1'b0;
        tx_idle_pct = 24;
        rx_idle_pct = 45;
        drive_phase = 1'b0;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            pt_avg[i] = '0;
            q_avg[i]  = '0;
        end

        directed_rows[0]  = make_row( 0, 16'h0000, 0, 1, 0,     0, 0);
        directed_rows[1]  = make_row( 1, 16'hFFFF, 0, 1, 0,  2047, 0);
        directed_rows[2]  = make_row(31, 16'hFFFF, 0, 1, 0,  2047, 0);
        directed_rows[3]  = make_row( 2, 16'hFFFF, 1, 1, 1, -2048, 0);
        directed_rows[4]  = make_row(30, 16'h0000, 0, 1, 1,     0, 0);
        directed_rows[5]  = make_row( 1, 16'h0000, 0, 0, 0, 0, 0);
        directed_rows[6]  = make_row( 1, 16'h0000, 0, 0, 0, 0, 0);
        directed_rows[7]  = make_row( 1, 16'h0001, 1, 0, 0, 0, 0);
        directed_rows[8]  = make_row(31, 16'hFFFF, 0, 0, 0, 0, 0);
        directed_rows[9]  = make_row(31, 16'hFFFF, 0, 0, 0, 0, 0);
        directed_rows[10] = make_row(31, 16'h0000, 1, 0, 0, 0, 0);
        directed_rows[11] = make_row(31, 16'h0000, 0, 0, 0, 0, 0);
        directed_rows[12] = make_row(21, 16'h5555, 0, 0, 0, 0, 0);
        directed_rows[13] = make_row(10, 16'hAAAA, 1, 0, 0, 0, 0);
        directed_rows[14] = make_row(10, 16'hAAAA, 0, 0, 0, 0, 0);
        directed_rows[15] = make_row( 2, 16'hFFFF, 0, 0, 0, 0, 0);
        directed_rows[16] = make_row( 2, 16'h0000, 1, 0, 0, 0, 0);
        directed_rows[17] = make_row( 0, 16'h8000, 0, 0, 0, 0, 0);
        directed_rows[18] = make_row( 0, 16'h7FFF, 1, 0, 0, 0, 0);
        directed_rows[19] = make_row(31, 16'hFFFF, 1, 0, 0, 0, 0);

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            send_sample(directed_rows[i].channel, directed_rows[i].sample,
                        directed_rows[i].toggle, directed_rows[i].fixed,
                        directed_rows[i].fixed_update);
        end
        wait_drained();

        // long receiver stall while samples keep coming
        rx_hold_req = 1'b1;
        run_random(ITEMS_PER_PHASE);
        wait_drained();

        tx_idle_pct = 45;
        rx_idle_pct = 24;
        run_random(ITEMS_PER_PHASE);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(ITEMS_PER_PHASE);
        wait_drained();

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0 && expected_updates.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
